// ===== hw/rtl/clipped_blit_alpha_blend_macros.svh =====
// ---------------------------------------------------------------------------
// clipped_blit_alpha_blend_macros.svh
// Assertion shorthands for the blit checker. The checker provides clk and rst_n.
// ---------------------------------------------------------------------------
`ifndef CLIPPED_BLIT_ALPHA_BLEND_MACROS_SVH
`define CLIPPED_BLIT_ALPHA_BLEND_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CBAB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cbab checker: same-cycle property failed");

// Consequent must hold in the cycle after the antecedent.
`define CBAB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cbab checker: next-cycle property failed");

`endif

// ===== hw/rtl/cbab_pkg.sv =====
// ---------------------------------------------------------------------------
// cbab_pkg
// Shared types, codes and sizes for the clipped blit / alpha blend engine.
// ---------------------------------------------------------------------------
`default_nettype none

package cbab_pkg;

    // Field widths
    localparam int DIM_W   = 13;
    localparam int POS_W   = DIM_W + 1;
    localparam int PROD_W  = POS_W + DIM_W;
    localparam int IDX_W   = 24;
    localparam int PIX_W   = 32;
    localparam int FMT_W   = 2;
    localparam int STAT_W  = 2;
    localparam int CFG_IDX_W = 3;

    // Defaults for top-level parameters
    localparam int MAX_DIM_DEF     = 4096;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Request types
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_BLIT = 2'd2;

    // Source formats
    localparam logic [FMT_W-1:0] FMT_RGB  = 2'd0;
    localparam logic [FMT_W-1:0] FMT_RGBA = 2'd1;

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_FORMAT = 3'd4;

    // Input word
    typedef struct packed {
        logic             req_type;
        logic [DIM_W-1:0] src_x;
        logic [DIM_W-1:0] src_y;
        logic [DIM_W-1:0] dst_x;
        logic [DIM_W-1:0] dst_y;
        logic [DIM_W-1:0] rect_width;
        logic [DIM_W-1:0] rect_height;
        logic [PIX_W-1:0] src_pixel;
        logic [PIX_W-1:0] dst_pixel;
    } blit_in_t;

    // Output word
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [DIM_W-1:0]  clipped_width;
        logic [DIM_W-1:0]  clipped_height;
        logic [IDX_W-1:0]  dst_index;
        logic [PIX_W-1:0]  out_pixel;
        logic              last;
    } blit_out_t;

    // Configuration as seen by front and back
    typedef struct packed {
        logic [DIM_W-1:0] src_width;
        logic [DIM_W-1:0] src_height;
        logic [DIM_W-1:0] dst_width;
        logic [DIM_W-1:0] dst_height;
        logic [FMT_W-1:0] source_format;
    } cbab_cfg_t;

    // Classified item handed from front to back
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              is_pixel;
        logic [DIM_W-1:0]  clip_w;
        logic [DIM_W-1:0]  clip_h;
        logic [POS_W-1:0]  row_pos;
        logic [POS_W-1:0]  col_pos;
        logic              last;
        logic [PIX_W-1:0]  src_pixel;
        logic [PIX_W-1:0]  dst_pixel;
    } cbab_entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cbab_front.sv =====
// ---------------------------------------------------------------------------
// cbab_front
// Accepts words, checks and clips start requests, walks the raster position
// of pixel words, and pushes one classified entry per word into the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module cbab_front
    import cbab_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  blit_in_t    in_data,
    input  cbab_cfg_t   cfg,
    input  logic        q_full,
    output logic        q_push,
    output cbab_entry_t q_entry
);

    logic             active_reg, active_next;
    logic [DIM_W-1:0] row_reg, row_next;
    logic [DIM_W-1:0] col_reg, col_next;
    logic [DIM_W-1:0] clip_w_reg, clip_w_next;
    logic [DIM_W-1:0] clip_h_reg, clip_h_next;
    logic [DIM_W-1:0] orig_x_reg, orig_x_next;
    logic [DIM_W-1:0] orig_y_reg, orig_y_next;

    logic             accept;
    logic             start_bad;
    logic [DIM_W-1:0] src_w_rem, src_h_rem, dst_w_rem, dst_h_rem;
    logic [DIM_W-1:0] fit_w0, fit_h0, fit_w, fit_h;
    logic [POS_W-1:0] col_inc, row_inc;
    logic             end_row, fin;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign q_push   = accept;

    // Start geometry: remaining room in each bitmap, then clip
    assign src_w_rem = cfg.src_width  - in_data.src_x;
    assign src_h_rem = cfg.src_height - in_data.src_y;
    assign dst_w_rem = cfg.dst_width  - in_data.dst_x;
    assign dst_h_rem = cfg.dst_height - in_data.dst_y;

    assign start_bad = (in_data.src_x > cfg.src_width)  ||
                       (in_data.src_y > cfg.src_height) ||
                       (in_data.dst_x > cfg.dst_width)  ||
                       (in_data.dst_y > cfg.dst_height) ||
                       (in_data.rect_width  > src_w_rem) ||
                       (in_data.rect_height > src_h_rem);

    assign fit_w0 = (dst_w_rem < src_w_rem) ? dst_w_rem : src_w_rem;
    assign fit_h0 = (dst_h_rem < src_h_rem) ? dst_h_rem : src_h_rem;
    assign fit_w  = (in_data.rect_width  < fit_w0) ? in_data.rect_width  : fit_w0;
    assign fit_h  = (in_data.rect_height < fit_h0) ? in_data.rect_height : fit_h0;

    // Raster walk: end of row, end of rectangle
    assign col_inc = {1'b0, col_reg} + POS_W'(1);
    assign row_inc = {1'b0, row_reg} + POS_W'(1);
    assign end_row = col_inc >= {1'b0, clip_w_reg};
    assign fin     = end_row && (row_inc >= {1'b0, clip_h_reg});

    // Classify and compute next walk state
    always_comb
    begin
        active_next = active_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        clip_w_next = clip_w_reg;
        clip_h_next = clip_h_reg;
        orig_x_next = orig_x_reg;
        orig_y_next = orig_y_reg;

        q_entry           = '0;
        q_entry.src_pixel = in_data.src_pixel;
        q_entry.dst_pixel = in_data.dst_pixel;

        if (in_data.req_type == REQ_START)
        begin
            // a start always drops any running blit
            active_next = 1'b0;
            row_next    = '0;
            col_next    = '0;
            if (start_bad)
            begin
                clip_w_next    = '0;
                clip_h_next    = '0;
                q_entry.status = ST_INVALID;
            end
            else
            begin
                clip_w_next    = fit_w;
                clip_h_next    = fit_h;
                orig_x_next    = in_data.dst_x;
                orig_y_next    = in_data.dst_y;
                active_next    = (fit_w != '0) && (fit_h != '0);
                q_entry.status = ST_OK;
                q_entry.clip_w = fit_w;
                q_entry.clip_h = fit_h;
            end
        end
        else if (!active_reg)
        begin
            q_entry.status = ST_NO_BLIT;
        end
        else
        begin
            q_entry.status   = ST_OK;
            q_entry.is_pixel = 1'b1;
            q_entry.row_pos  = {1'b0, orig_y_reg} + {1'b0, row_reg};
            q_entry.col_pos  = {1'b0, orig_x_reg} + {1'b0, col_reg};
            q_entry.last     = fin;
            if (fin)
            begin
                active_next = 1'b0;
                row_next    = '0;
                col_next    = '0;
            end
            else if (end_row)
            begin
                col_next = '0;
                row_next = row_inc[DIM_W-1:0];
            end
            else
            begin
                col_next = col_inc[DIM_W-1:0];
            end
        end
    end

    // Walk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            row_reg    <= '0;
            col_reg    <= '0;
            clip_w_reg <= '0;
            clip_h_reg <= '0;
            orig_x_reg <= '0;
            orig_y_reg <= '0;
        end
        else if (accept)
        begin
            active_reg <= active_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            clip_w_reg <= clip_w_next;
            clip_h_reg <= clip_h_next;
            orig_x_reg <= orig_x_next;
            orig_y_reg <= orig_y_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cbab_queue.sv =====
// ---------------------------------------------------------------------------
// cbab_queue
// Small FIFO of classified entries between front and back.
// ---------------------------------------------------------------------------
`default_nettype none

module cbab_queue
    import cbab_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  cbab_entry_t push_data,
    input  logic        pop,
    output cbab_entry_t pop_data,
    output logic        full,
    output logic        empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cbab_entry_t      mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = count_reg == CNT_W'(DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = mem[rd_ptr_reg];

    // Pointer wrap and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cbab_back.sv =====
// ---------------------------------------------------------------------------
// cbab_back
// Two-stage execution: multiply stage (row times stride, channel products),
// then index add, pixel compose and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module cbab_back
    import cbab_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cbab_cfg_t   cfg,
    input  logic        q_empty,
    input  cbab_entry_t q_data,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_stall,
    output blit_out_t   out_data
);

    localparam int CH_W = 8;
    localparam int NCH  = 3;

    // Stage 1 registers
    logic              s1_valid_reg, s1_valid_next;
    logic [STAT_W-1:0] s1_status_reg;
    logic              s1_is_pixel_reg;
    logic [DIM_W-1:0]  s1_clip_w_reg, s1_clip_h_reg;
    logic [POS_W-1:0]  s1_col_reg;
    logic              s1_last_reg;
    logic [PIX_W-1:0]  s1_src_reg, s1_dst_reg;
    logic [PROD_W-1:0] s1_prod_reg;
    logic [CH_W-1:0]   s1_sa_reg [NCH];
    logic [CH_W-1:0]   s1_da_reg [NCH];

    // Output register
    logic              out_valid_reg, out_valid_next;
    blit_out_t         out_data_reg, out_data_next;

    logic              out_adv, s1_adv;
    logic [CH_W-1:0]   alpha, inv_alpha;
    logic [2*CH_W-1:0] sa_prod [NCH];
    logic [2*CH_W-1:0] da_prod [NCH];
    logic [CH_W:0]     ch_sum [NCH];
    logic [PIX_W-1:0]  blend_pix;

    // Stall propagates back from the output register
    assign out_adv   = !out_valid_reg || !out_stall;
    assign s1_adv    = !s1_valid_reg || out_adv;
    assign q_pop     = !q_empty && s1_adv;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Channel products, one per color channel
    assign alpha     = q_data.src_pixel[PIX_W-1 -: CH_W];
    assign inv_alpha = 8'd255 - alpha;

    always_comb
    begin
        for (int c = 0; c < NCH; c++)
        begin
            sa_prod[c] = q_data.src_pixel[CH_W*c +: CH_W] * alpha;
            da_prod[c] = q_data.dst_pixel[CH_W*c +: CH_W] * inv_alpha;
        end
    end

    // Stage 1 control
    always_comb
    begin
        s1_valid_next = s1_adv ? q_pop : s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_status_reg   <= q_data.status;
            s1_is_pixel_reg <= q_data.is_pixel;
            s1_clip_w_reg   <= q_data.clip_w;
            s1_clip_h_reg   <= q_data.clip_h;
            s1_col_reg      <= q_data.col_pos;
            s1_last_reg     <= q_data.last;
            s1_src_reg      <= q_data.src_pixel;
            s1_dst_reg      <= q_data.dst_pixel;
            s1_prod_reg     <= PROD_W'(q_data.row_pos) * PROD_W'(cfg.dst_width);
            for (int c = 0; c < NCH; c++)
            begin
                s1_sa_reg[c] <= sa_prod[c][2*CH_W-1 -: CH_W];
                s1_da_reg[c] <= da_prod[c][2*CH_W-1 -: CH_W];
            end
        end
    end

    // Blend sums; each stays below 255
    always_comb
    begin
        for (int c = 0; c < NCH; c++)
        begin
            ch_sum[c] = {1'b0, s1_sa_reg[c]} + {1'b0, s1_da_reg[c]};
        end
        blend_pix = {s1_dst_reg[PIX_W-1 -: CH_W], ch_sum[2][CH_W-1:0],
                     ch_sum[1][CH_W-1:0], ch_sum[0][CH_W-1:0]};
    end

    // Result word
    always_comb
    begin
        out_data_next                = '0;
        out_data_next.status         = s1_status_reg;
        out_data_next.clipped_width  = s1_clip_w_reg;
        out_data_next.clipped_height = s1_clip_h_reg;
        if (s1_is_pixel_reg)
        begin
            out_data_next.dst_index = s1_prod_reg[IDX_W-1:0] + IDX_W'(s1_col_reg);
            out_data_next.last      = s1_last_reg;
            case (cfg.source_format)
                FMT_RGB:
                    out_data_next.out_pixel = {s1_dst_reg[PIX_W-1 -: CH_W],
                                               s1_src_reg[PIX_W-CH_W-1:0]};
                FMT_RGBA:
                    out_data_next.out_pixel = blend_pix;
                default:
                    out_data_next.out_pixel = s1_dst_reg;
            endcase
        end
        out_valid_next = out_adv ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && s1_valid_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/clipped_blit_alpha_blend.sv =====
// ---------------------------------------------------------------------------
// clipped_blit_alpha_blend
// Clipped rectangle blit with per-channel alpha blend: config registers,
// front end (check, clip, raster walk), entry queue, back end (index, pixel).
//
//   channel | dir | handshake            | payload
//   in      | in  | in_valid / in_stall   | in_data  (blit_in_t)
//   out     | out | out_valid / out_stall | out_data (blit_out_t)
//   cfg     | in  | cfg_we                | cfg_index, cfg_data
//
// Sustained rate is one word per cycle on both channels while out_stall is low.
// A result shows on out_valid once its word has passed the queue, the multiply
// stage (row times stride) and the output register.
// in_stall rises only when the entry queue (QUEUE_DEPTH words) is full.
// out_stall freezes the back end; the front keeps filling the queue.
// Reset takes effect at once: sizes read 1, format rgb, no blit active.
// ---------------------------------------------------------------------------
`default_nettype none

module clipped_blit_alpha_blend
    import cbab_pkg::*;
#(
    parameter int MAX_DIM     = MAX_DIM_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  blit_in_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output blit_out_t            out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data
);

    localparam int               CMP_W      = 17;
    localparam logic [CMP_W-1:0] MaxDimWide = CMP_W'(MAX_DIM);

    cbab_cfg_t        cfg_reg, cfg_next;
    logic [DIM_W-1:0] size_sat;

    logic             q_push, q_pop, q_full, q_empty;
    cbab_entry_t      q_wr, q_rd;

    // Size registers saturate at MAX_DIM
    assign size_sat = ({(CMP_W-DIM_W)'(0), cfg_data} > MaxDimWide) ?
                      MaxDimWide[DIM_W-1:0] : cfg_data;

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SRC_WIDTH:  cfg_next.src_width     = size_sat;
                REG_SRC_HEIGHT: cfg_next.src_height    = size_sat;
                REG_DST_WIDTH:  cfg_next.dst_width     = size_sat;
                REG_DST_HEIGHT: cfg_next.dst_height    = size_sat;
                REG_SRC_FORMAT: cfg_next.source_format = cfg_data[FMT_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.src_width     <= DIM_W'(1);
            cfg_reg.src_height    <= DIM_W'(1);
            cfg_reg.dst_width     <= DIM_W'(1);
            cfg_reg.dst_height    <= DIM_W'(1);
            cfg_reg.source_format <= FMT_RGB;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end
    cbab_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_wr)
    );

    // Entry queue
    cbab_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wr),
        .pop       (q_pop),
        .pop_data  (q_rd),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Back end
    cbab_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_data    (q_rd),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/cbab_checker.sv =====
// ---------------------------------------------------------------------------
// cbab_checker
// Port-level checks on the result channel of the blit engine.
// ---------------------------------------------------------------------------
`default_nettype none

`include "clipped_blit_alpha_blend_macros.svh"

module cbab_checker
    import cbab_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_stall,
    input blit_out_t out_data
);

    // A held result stays put
    `CBAB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

    // No-blit answers carry nothing else
    `CBAB_ASSERT_NOW(a_no_blit_clean, out_valid && (out_data.status == ST_NO_BLIT), (out_data.dst_index == '0) && (out_data.out_pixel == '0) && !out_data.last && (out_data.clipped_width == '0) && (out_data.clipped_height == '0))

    // Invalid starts report an empty clip
    `CBAB_ASSERT_NOW(a_invalid_clean, out_valid && (out_data.status == ST_INVALID), (out_data.clipped_width == '0) && (out_data.clipped_height == '0) && !out_data.last)

    // The end-of-rectangle mark only rides on ok pixel results
    `CBAB_ASSERT_NOW(a_last_on_pixel, out_valid && out_data.last, (out_data.status == ST_OK) && (out_data.clipped_width == '0) && (out_data.clipped_height == '0))

endmodule

bind clipped_blit_alpha_blend cbab_checker u_cbab_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb - clipped blit / alpha blend engine
// Drives start and pixel words through the valid/stall channels, programs the
// bitmap sizes and source format between phases, and checks every result word
// against an in-bench prediction of the clip, raster walk, index and blend.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cbab_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 6;
    localparam int RANDOM_PER_MODE = 500;
    localparam int PHASES_PER_MODE = 4;
    localparam int LONG_HOLD       = 60;

    localparam logic [FMT_W-1:0] FMT_KEEP    = 2'd2;
    localparam logic [FMT_W-1:0] FMT_KEEP_HI = 2'd3;
    localparam logic [DIM_W-1:0] DIM_ALL     = 13'h1FFF;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    blit_in_t             in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    blit_out_t            out_data;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data  = '0;

    // shadow registers
    logic [DIM_W-1:0] sw_reg  = 13'd1;
    logic [DIM_W-1:0] sh_reg  = 13'd1;
    logic [DIM_W-1:0] dw_reg  = 13'd1;
    logic [DIM_W-1:0] dh_reg  = 13'd1;
    logic [FMT_W-1:0] fmt_reg = FMT_RGB;

    // shadow raster state
    logic             blit_on = 1'b0;
    logic [DIM_W-1:0] row_at  = '0;
    logic [DIM_W-1:0] col_at  = '0;
    logic [DIM_W-1:0] span_w  = '0;
    logic [DIM_W-1:0] span_h  = '0;
    logic [DIM_W-1:0] org_x   = '0;
    logic [DIM_W-1:0] org_y   = '0;

    blit_out_t expected_q[$];
    blit_out_t want_word;
    int        failures       = 0;
    int        cycle_count    = 0;
    int        send_gap_pct   = 0;
    int        recv_stall_pct = 0;
    int        hold_left      = 0;

    clipped_blit_alpha_blend dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic int smaller(input int a, input int b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [DIM_W-1:0] clamp_size(input logic [DIM_W-1:0] v);
        return (int'(v) > MAX_DIM_DEF) ? DIM_W'(MAX_DIM_DEF) : v;
    endfunction

    function automatic logic [7:0] blend_channel(input logic [7:0] s, input logic [7:0] d,
                                                 input logic [7:0] a);
        int mix;
        mix = ((int'(s) * int'(a)) >> 8) + ((int'(d) * (255 - int'(a))) >> 8);
        return mix[7:0];
    endfunction

    function automatic logic [PIX_W-1:0] blended_pixel(input logic [PIX_W-1:0] s,
                                                       input logic [PIX_W-1:0] d);
        case (fmt_reg)
            FMT_RGB:  return {d[31:24], s[23:0]};
            FMT_RGBA: return {d[31:24],
                              blend_channel(s[23:16], d[23:16], s[31:24]),
                              blend_channel(s[15:8],  d[15:8],  s[31:24]),
                              blend_channel(s[7:0],   d[7:0],   s[31:24])};
            default:  return d;
        endcase
    endfunction

    // Result of one word; advances the shadow raster state.
    function automatic blit_out_t predict_result(input blit_in_t w);
        blit_out_t r;
        int        sx, sy, dx, dy, rw, rh, sw, sh, dw, dh, cw, ch, line;
        logic      end_row, fin;
        r  = '0;
        sw = int'(sw_reg);
        sh = int'(sh_reg);
        dw = int'(dw_reg);
        dh = int'(dh_reg);
        if (w.req_type == REQ_START)
        begin
            sx = int'(w.src_x);
            sy = int'(w.src_y);
            dx = int'(w.dst_x);
            dy = int'(w.dst_y);
            rw = int'(w.rect_width);
            rh = int'(w.rect_height);
            blit_on = 1'b0;
            row_at  = '0;
            col_at  = '0;
            if (sx > sw || sy > sh || dx > dw || dy > dh || rw > sw - sx || rh > sh - sy)
            begin
                span_w   = '0;
                span_h   = '0;
                r.status = ST_INVALID;
            end
            else
            begin
                cw = smaller(smaller(dw - dx, sw - sx), rw);
                ch = smaller(smaller(dh - dy, sh - sy), rh);
                span_w  = cw[DIM_W-1:0];
                span_h  = ch[DIM_W-1:0];
                org_x   = dx[DIM_W-1:0];
                org_y   = dy[DIM_W-1:0];
                blit_on = (cw != 0) && (ch != 0);
                r.status         = ST_OK;
                r.clipped_width  = cw[DIM_W-1:0];
                r.clipped_height = ch[DIM_W-1:0];
            end
        end
        else if (!blit_on)
        begin
            r.status = ST_NO_BLIT;
        end
        else
        begin
            line    = (int'(org_y) + int'(row_at)) * dw + int'(org_x) + int'(col_at);
            end_row = (int'(col_at) + 1 >= int'(span_w));
            fin     = end_row && (int'(row_at) + 1 >= int'(span_h));
            r.status    = ST_OK;
            r.dst_index = line[IDX_W-1:0];
            r.out_pixel = blended_pixel(w.src_pixel, w.dst_pixel);
            r.last      = fin;
            if (fin)
            begin
                blit_on = 1'b0;
                row_at  = '0;
                col_at  = '0;
            end
            else if (end_row)
            begin
                col_at = '0;
                row_at = row_at + DIM_W'(1);
            end
            else
            begin
                col_at = col_at + DIM_W'(1);
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Word builders
    // ------------------------------------------------------------------
    function automatic blit_in_t random_word();
        blit_in_t w;
        w.req_type    = 1'($urandom_range(1));
        w.src_x       = DIM_W'($urandom);
        w.src_y       = DIM_W'($urandom);
        w.dst_x       = DIM_W'($urandom);
        w.dst_y       = DIM_W'($urandom);
        w.rect_width  = DIM_W'($urandom);
        w.rect_height = DIM_W'($urandom);
        w.src_pixel   = PIX_W'($urandom);
        w.dst_pixel   = PIX_W'($urandom);
        return w;
    endfunction

    function automatic blit_in_t start_word(input int sx, input int sy, input int dx,
                                            input int dy, input int rw, input int rh);
        blit_in_t w;
        w = random_word();
        w.req_type    = REQ_START;
        w.src_x       = sx[DIM_W-1:0];
        w.src_y       = sy[DIM_W-1:0];
        w.dst_x       = dx[DIM_W-1:0];
        w.dst_y       = dy[DIM_W-1:0];
        w.rect_width  = rw[DIM_W-1:0];
        w.rect_height = rh[DIM_W-1:0];
        return w;
    endfunction

    function automatic blit_in_t pixel_pair(input logic [PIX_W-1:0] s,
                                            input logic [PIX_W-1:0] d);
        blit_in_t w;
        w = random_word();
        w.req_type  = REQ_PIXEL;
        w.src_pixel = s;
        w.dst_pixel = d;
        return w;
    endfunction

    // random pixels, with alpha pinned to its ends now and then
    function automatic blit_in_t random_pixel();
        blit_in_t w;
        w = pixel_pair(PIX_W'($urandom), PIX_W'($urandom));
        case ($urandom_range(7))
            0: w.src_pixel[31:24] = 8'h00;
            1: w.src_pixel[31:24] = 8'hFF;
            default: ;
        endcase
        return w;
    endfunction

    function automatic logic [DIM_W-1:0] pick_size();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return DIM_W'($urandom_range(1, 12));
        else if (roll < 80)
            return DIM_W'($urandom_range(13, MAX_DIM_DEF));
        else if (roll < 87)
            return DIM_W'(MAX_DIM_DEF);
        else if (roll < 93)
            return '0;
        else
            return DIM_W'($urandom_range(MAX_DIM_DEF + 1, int'(DIM_ALL)));
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic send_word(input blit_in_t w);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_gap_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_q.push_back(predict_result(w));
    endtask

    // Drop any running blit, stop sending and wait for every result.
    task automatic settle_block();
        if (blit_on)
            send_word(start_word(int'(DIM_ALL), 0, 0, 0, 0, 0));
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_SRC_WIDTH:  sw_reg  = clamp_size(val);
            REG_SRC_HEIGHT: sh_reg  = clamp_size(val);
            REG_DST_WIDTH:  dw_reg  = clamp_size(val);
            REG_DST_HEIGHT: dh_reg  = clamp_size(val);
            REG_SRC_FORMAT: fmt_reg = val[FMT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [DIM_W-1:0] sw, input logic [DIM_W-1:0] sh,
                                input logic [DIM_W-1:0] dw, input logic [DIM_W-1:0] dh,
                                input logic [FMT_W-1:0] fmt);
        logic [DIM_W-1:0] fmt_data;
        fmt_data = DIM_W'($urandom);
        fmt_data[FMT_W-1:0] = fmt;
        write_reg(REG_SRC_WIDTH, sw);
        write_reg(REG_SRC_HEIGHT, sh);
        write_reg(REG_DST_WIDTH, dw);
        write_reg(REG_DST_HEIGHT, dh);
        write_reg(REG_SRC_FORMAT, fmt_data);
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall, or a long hold when one is requested
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
            failures++;
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t unexpected result word: expected none actual %h",
                         $time, out_data);
                failures++;
            end
            else
            begin
                want_word = expected_q.pop_front();
                check_field("status", 32'(want_word.status), 32'(out_data.status));
                check_field("clipped_width", 32'(want_word.clipped_width),
                            32'(out_data.clipped_width));
                check_field("clipped_height", 32'(want_word.clipped_height),
                            32'(out_data.clipped_height));
                check_field("dst_index", 32'(want_word.dst_index),
                            32'(out_data.dst_index));
                check_field("out_pixel", want_word.out_pixel, out_data.out_pixel);
                check_field("last", 32'(want_word.last), 32'(out_data.last));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset sizes are 1x1, format rgb.
    task automatic test_reset_defaults();
        send_word(pixel_pair(32'hFFFF_FFFF, 32'h0000_0000));
        send_word(start_word(0, 0, 0, 0, 1, 1));
        send_word(pixel_pair(32'h1234_5678, 32'hAB00_0000));
        send_word(pixel_pair(32'h0000_0000, 32'hFFFF_FFFF));
        send_word(start_word(0, 0, 0, 0, 2, 1));
        send_word(start_word(1, 0, 0, 0, 0, 0));
        send_word(start_word(0, 0, 1, 1, 1, 1));
        send_word(start_word(2, 0, 0, 0, 0, 0));
        send_word(start_word(0, 0, 0, 2, 0, 0));
        settle_block();
    endtask

    // Saturating size writes, corner index, blend extremes, restart mid-blit.
    task automatic test_register_extremes();
        program_regs(DIM_ALL, 13'd4096, 13'd5000, 13'd4096, FMT_RGBA);
        send_word(start_word(0, 0, 4095, 4095, 3, 2));
        send_word(pixel_pair(32'hFFFF_FFFF, 32'h0000_0000));
        send_word(start_word(4096, 4096, 0, 0, 0, 0));
        send_word(start_word(int'(DIM_ALL), 0, 0, 0, 0, 0));
        send_word(start_word(0, 0, 0, 0, int'(DIM_ALL), 1));
        send_word(start_word(0, 0, 0, 0, 4096, 4096));
        send_word(start_word(0, 0, 1, 0, 2, 2));
        send_word(pixel_pair(32'h00FF_FFFF, 32'hFFFF_FFFF));
        send_word(start_word(5, 7, 4094, 9, 2, 2));
        send_word(pixel_pair(32'h8040_2010, 32'h7F00_00FF));
        repeat (3) send_word(random_pixel());
        settle_block();
    endtask

    // Formats that leave the pixel alone, and a zero size register.
    task automatic test_formats();
        program_regs(13'd3, 13'd2, 13'd4, 13'd5, FMT_KEEP);
        send_word(start_word(2, 0, 2, 3, 1, 2));
        repeat (2) send_word(random_pixel());
        settle_block();
        program_regs(13'd0, 13'd2, 13'd4, 13'd5, FMT_KEEP_HI);
        send_word(start_word(0, 0, 0, 0, 0, 1));
        send_word(random_pixel());
        settle_block();
    endtask

    // Receiver holds off while the sender keeps offering a long blit.
    task automatic test_backpressure();
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        program_regs(13'd12, 13'd12, 13'd12, 13'd12, FMT_RGBA);
        hold_left <= LONG_HOLD;
        send_word(start_word(1, 2, 3, 4, 5, 5));
        repeat (25) send_word(random_pixel());
        settle_block();
    endtask

    // Mostly well-formed blits with random geometry; some cut short or
    // overrun, plus stray starts and pixels.
    task automatic random_traffic(input int n_items);
        int done, pick, cut, pixels;
        int sx, sy, dx, dy, rw, rh;
        done = 0;
        while (done < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 75)
            begin
                sx = $urandom_range(int'(sw_reg));
                sy = $urandom_range(int'(sh_reg));
                rw = $urandom_range(smaller(int'(sw_reg) - sx, 6));
                rh = $urandom_range(smaller(int'(sh_reg) - sy, 6));
                if ($urandom_range(3) == 0)
                    dx = int'(dw_reg) - int'($urandom_range(smaller(int'(dw_reg), 3)));
                else
                    dx = $urandom_range(int'(dw_reg));
                if ($urandom_range(3) == 0)
                    dy = int'(dh_reg) - int'($urandom_range(smaller(int'(dh_reg), 3)));
                else
                    dy = $urandom_range(int'(dh_reg));
                send_word(start_word(sx, sy, dx, dy, rw, rh));
                done++;
                pixels = blit_on ? int'(span_w) * int'(span_h) : 0;
                cut = $urandom_range(99);
                if (cut < 8 && pixels > 1)
                    pixels = $urandom_range(1, pixels - 1);
                else if (cut < 16)
                    pixels++;
                repeat (pixels)
                begin
                    send_word(random_pixel());
                    done++;
                end
            end
            else if (pick < 88)
            begin
                send_word(start_word($urandom, $urandom, $urandom, $urandom,
                                     $urandom, $urandom));
                done++;
            end
            else
            begin
                send_word(random_pixel());
                done++;
            end
        end
    endtask

    task automatic test_random(input int send_pct, input int recv_pct);
        send_gap_pct   = send_pct;
        recv_stall_pct = recv_pct;
        repeat (PHASES_PER_MODE)
        begin
            program_regs(pick_size(), pick_size(), pick_size(), pick_size(),
                         FMT_W'($urandom_range(3)));
            random_traffic(RANDOM_PER_MODE / PHASES_PER_MODE);
            settle_block();
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_register_extremes();
        test_formats();
        test_backpressure();
        test_random(19, 87);
        test_random(87, 19);
        test_random(0, 0);
        if (failures == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
